// ----- src/afs_pkg.sv -----
// ----------------------------------------------------------------------------
// afs_pkg: shared definitions for the arm/disarm failsafe supervisor
// Types, register indexes, reset values and sizing constants used by the
// interfaces, the channel lanes, the state core and the top level.
// ----------------------------------------------------------------------------
package afs_pkg;

  // Number of RC channels carried by one tick and checked in parallel lanes.
  localparam int unsigned MAX_CHANNELS = 8;
  // Failsafe blink counter limit; the LED toggles once the count exceeds it.
  localparam int unsigned BLINK_LIMIT  = 25;
  localparam int unsigned BLINK_W      = $clog2(BLINK_LIMIT + 2);

  localparam int unsigned PULSE_W      = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  // Q15 unity, used for the stick margin.
  localparam logic signed [17:0] Q15_ONE = 18'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARM_THRESHOLD   = 3'd0,
    CFG_CHANNELS_IN_USE = 3'd1,
    CFG_PWM_LOW         = 3'd2,
    CFG_PWM_HIGH        = 3'd3,
    CFG_HOLD_MS         = 3'd4,
    CFG_PERIOD_MS       = 3'd5
  } afs_cfg_idx_e;

  localparam logic [15:0] RST_ARM_THRESHOLD   = 16'd4915;
  localparam logic [3:0]  RST_CHANNELS_IN_USE = 4'd8;
  localparam logic [15:0] RST_PWM_LOW         = 16'd900;
  localparam logic [15:0] RST_PWM_HIGH        = 16'd2100;
  localparam logic [15:0] RST_HOLD_MS         = 16'd500;
  localparam logic [15:0] RST_PERIOD_MS       = 16'd20;

  typedef struct packed {
    logic [15:0] arm_threshold;
    logic [3:0]  channels_in_use;
    logic [15:0] pwm_low;
    logic [15:0] pwm_high;
    logic [15:0] hold_ms;
    logic [15:0] period_ms;
  } afs_cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               link_lost;
    logic [63:0]        pulses_low;
    logic [63:0]        pulses_high;
    logic signed [15:0] throttle;
    logic signed [15:0] yaw;
    logic               switch_mapped;
    logic               switch_on;
    logic               calibration_done;
  } afs_in_t;

  // Tick after the lane stage: the pulse widths are reduced to one flag.
  typedef struct packed {
    logic [31:0]        now_ms;
    logic               link_lost;
    logic               pulse_bad;
    logic signed [15:0] throttle;
    logic signed [15:0] yaw;
    logic               switch_mapped;
    logic               switch_on;
    logic               calibration_done;
  } afs_step_t;

  typedef struct packed {
    logic updated;
    logic in_failsafe;
    logic is_armed;
    logic rc_lost_error;
    logic start_calibration;
    logic led;
  } afs_out_t;

endpackage

// ----- src/afs_in_if.sv -----
// ----------------------------------------------------------------------------
// afs_in_if: tick input channel
// Valid/ready channel carrying one supervisor tick per transfer.
// ----------------------------------------------------------------------------
interface afs_in_if
  import afs_pkg::*;
();
  logic    valid;
  logic    ready;
  afs_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/afs_out_if.sv -----
// ----------------------------------------------------------------------------
// afs_out_if: result output channel
// Valid/ready channel carrying one supervisor result per transfer.
// ----------------------------------------------------------------------------
interface afs_out_if
  import afs_pkg::*;
();
  logic     valid;
  logic     ready;
  afs_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/afs_lane.sv -----
// ----------------------------------------------------------------------------
// afs_lane: single RC channel range check
// Flags a channel that is in use and whose pulse width lies outside the
// configured valid window.
// ----------------------------------------------------------------------------
module afs_lane
  import afs_pkg::*;
(
  input  logic               in_use_i,
  input  logic [PULSE_W-1:0] pulse_i,
  input  logic [15:0]        pwm_low_i,
  input  logic [15:0]        pwm_high_i,
  output logic               bad_o
);

  assign bad_o = in_use_i && ((pulse_i < pwm_low_i) || (pulse_i > pwm_high_i));

endmodule

// ----- src/afs_core.sv -----
// ----------------------------------------------------------------------------
// afs_core: supervisor state and update logic
// Holds the arming, failsafe and LED state and works out the next state and
// the result of one tick.
// ----------------------------------------------------------------------------
module afs_core
  import afs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  afs_step_t item_i,
  input  afs_cfg_t  cfg_i,
  output afs_out_t  res_o
);

  logic [31:0]        last_q, last_d;
  logic [31:0]        hold_q, hold_d;
  logic               armed_q, armed_d;
  logic               cal_q, cal_d;
  logic               lost_q, lost_d;
  logic               fs_q, fs_d;
  logic [BLINK_W-1:0] blink_q, blink_d;
  logic               led_q, led_d;

  logic [31:0]        dt;
  logic               upd;
  logic               fs;
  logic               req;
  logic [BLINK_W-1:0] blink_base;
  logic [32:0]        hold_sum;
  logic [31:0]        hold_nx;
  logic signed [17:0] thr;
  logic signed [17:0] margin;
  logic signed [17:0] thr_in;
  logic signed [17:0] yaw_in;
  logic               low_thr;
  logic               gesture;
  logic               arm_try;

  always_comb begin
    dt       = item_i.now_ms - last_q;
    upd      = dt >= {16'b0, cfg_i.period_ms};
    fs       = item_i.link_lost || item_i.pulse_bad;
    thr      = $signed({2'b00, cfg_i.arm_threshold});
    margin   = Q15_ONE - thr;
    thr_in   = 18'(item_i.throttle);
    yaw_in   = 18'(item_i.yaw);
    low_thr  = thr_in < thr;
    gesture  = armed_q ? (low_thr && (yaw_in < -margin))
                       : (low_thr && (yaw_in > margin));
    hold_sum = {1'b0, hold_q} + {1'b0, dt};
    if (!gesture) begin
      hold_nx = '0;
    end else if (hold_sum[32]) begin
      hold_nx = '1;
    end else begin
      hold_nx = hold_sum[31:0];
    end
    blink_base = (blink_q > BLINK_W'(BLINK_LIMIT)) ? '0 : blink_q;

    last_d  = last_q;
    hold_d  = hold_q;
    armed_d = armed_q;
    cal_d   = cal_q;
    lost_d  = lost_q;
    fs_d    = fs_q;
    blink_d = blink_q;
    led_d   = led_q;
    req     = 1'b0;
    arm_try = 1'b0;

    if (upd) begin
      last_d = item_i.now_ms;
      if (fs) begin
        if (blink_q > BLINK_W'(BLINK_LIMIT)) begin
          led_d = ~led_q;
        end
        blink_d = blink_base + BLINK_W'(1);
        fs_d    = 1'b1;
        if (item_i.link_lost) begin
          lost_d = 1'b1;
        end
      end else begin
        fs_d   = 1'b0;
        lost_d = 1'b0;
        if (!item_i.switch_mapped) begin
          hold_d = hold_nx;
          if (hold_nx > {16'b0, cfg_i.hold_ms}) begin
            if (!armed_q) begin
              arm_try = 1'b1;
            end else begin
              armed_d = 1'b0;
              led_d   = 1'b0;
              hold_d  = '0;
            end
          end
        end else if (item_i.switch_on) begin
          arm_try = !armed_q;
        end else begin
          armed_d = 1'b0;
          led_d   = 1'b0;
        end

        // The lost flag has just been cleared on this path, so an arm
        // attempt is never refused for lost link here.
        if (arm_try) begin
          if (!cal_q) begin
            req   = 1'b1;
            cal_d = 1'b1;
          end else if (item_i.calibration_done) begin
            cal_d   = 1'b0;
            armed_d = 1'b1;
            led_d   = 1'b1;
            // Only the stick path restarts the hold timer on arming.
            if (!item_i.switch_mapped) begin
              hold_d = '0;
            end
          end
        end
      end
    end

    res_o.updated           = upd;
    res_o.in_failsafe       = fs_d;
    res_o.is_armed          = armed_d;
    res_o.rc_lost_error     = lost_d;
    res_o.start_calibration = req;
    res_o.led               = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      hold_q  <= '0;
      armed_q <= 1'b0;
      cal_q   <= 1'b0;
      lost_q  <= 1'b0;
      fs_q    <= 1'b0;
      blink_q <= '0;
      led_q   <= 1'b0;
    end else if (step_i) begin
      last_q  <= last_d;
      hold_q  <= hold_d;
      armed_q <= armed_d;
      cal_q   <= cal_d;
      lost_q  <= lost_d;
      fs_q    <= fs_d;
      blink_q <= blink_d;
      led_q   <= led_d;
    end
  end

endmodule

// ----- src/arm_disarm_failsafe_supervisor.sv -----
// ----------------------------------------------------------------------------
// arm_disarm_failsafe_supervisor: arming and failsafe supervisor top level
// Checks RC channels in parallel lanes, then runs the arming state update.
// ----------------------------------------------------------------------------
// The supervisor takes one tick per clock cycle while the output is not stalled
// and returns one result per tick, through the lane stage register and then the
// output register. The first stage checks all eight RC pulse widths side by side,
// one lane per channel, and merges the lane flags; the second runs the update
// gate, the failsafe and arming logic and loads the output register. The two
// stages and the output register let a new tick be taken while a result still waits.
// Configuration registers are written through the plain write port and must
// only be changed while no tick is in flight.
module arm_disarm_failsafe_supervisor
  import afs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  afs_in_if.sink                in_i,
  afs_out_if.source             out_o
);

  afs_cfg_t  cfg_q;
  logic      s1_valid_q;
  afs_step_t s1_item_q;
  logic      out_valid_q;
  afs_out_t  out_q;
  afs_out_t  res;
  logic      s2_take;
  logic      in_take;

  logic [2*64-1:0]         pulses;
  logic [MAX_CHANNELS-1:0] lane_bad;

  assign s2_take     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s2_take;
  assign in_take     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_threshold   <= RST_ARM_THRESHOLD;
      cfg_q.channels_in_use <= RST_CHANNELS_IN_USE;
      cfg_q.pwm_low         <= RST_PWM_LOW;
      cfg_q.pwm_high        <= RST_PWM_HIGH;
      cfg_q.hold_ms         <= RST_HOLD_MS;
      cfg_q.period_ms       <= RST_PERIOD_MS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ARM_THRESHOLD:   cfg_q.arm_threshold   <= cfg_data_i;
        CFG_CHANNELS_IN_USE: cfg_q.channels_in_use <= cfg_data_i[3:0];
        CFG_PWM_LOW:         cfg_q.pwm_low         <= cfg_data_i;
        CFG_PWM_HIGH:        cfg_q.pwm_high        <= cfg_data_i;
        CFG_HOLD_MS:         cfg_q.hold_ms         <= cfg_data_i;
        CFG_PERIOD_MS:       cfg_q.period_ms       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Channel lanes. A lane is enabled when the count is above its lane number.
  assign pulses = {in_i.payload.pulses_high, in_i.payload.pulses_low};

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    afs_lane u_lane (
      .in_use_i   (4'(g) < cfg_q.channels_in_use),
      .pulse_i    (pulses[g*PULSE_W +: PULSE_W]),
      .pwm_low_i  (cfg_q.pwm_low),
      .pwm_high_i (cfg_q.pwm_high),
      .bad_o      (lane_bad[g])
    );
  end

  // Lane stage register with merged channel flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.now_ms           <= in_i.payload.now_ms;
      s1_item_q.link_lost        <= in_i.payload.link_lost;
      s1_item_q.pulse_bad        <= |lane_bad;
      s1_item_q.throttle         <= in_i.payload.throttle;
      s1_item_q.yaw              <= in_i.payload.yaw;
      s1_item_q.switch_mapped    <= in_i.payload.switch_mapped;
      s1_item_q.switch_on        <= in_i.payload.switch_on;
      s1_item_q.calibration_done <= in_i.payload.calibration_done;
    end
  end

  afs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s2_take),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      out_q <= res;
    end
  end

endmodule
